// File: src/kv_command_line_parser_assert.svh
// Assertion macros for the command line parser.
`ifndef KV_COMMAND_LINE_PARSER_ASSERT_SVH
`define KV_COMMAND_LINE_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication on i_clk, masked during reset
`define KVCLP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kv_command_line_parser: assertion failed");
// Next-cycle implication on i_clk, masked during reset
`define KVCLP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kv_command_line_parser: assertion failed");
`else
`define KVCLP_ASSERT_IMP(lbl, ante, cons)
`define KVCLP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: src/kvclp_pkg.sv
// Shared types, codes and constants of the command line parser.
package kvclp_pkg;

    // Operation codes
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_GET  = 2'd1;
    localparam logic [1:0] OP_SET  = 2'd2;
    localparam logic [1:0] OP_DEL  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_KEY     = 2'd0;
    localparam logic [1:0] KIND_VALUE   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // TTL parse phases
    localparam logic [1:0] TTL_LEAD   = 2'd0;
    localparam logic [1:0] TTL_DIGITS = 2'd1;
    localparam logic [1:0] TTL_STOP   = 2'd2;

    // Truncation limits
    localparam logic [7:0]  KEY_MAX_LEN   = 8'd255;
    localparam logic [10:0] VALUE_MAX_LEN = 11'd1024;

    localparam logic [30:0] MIN_TTL_RESET = 31'd10;

    // Register index
    localparam logic REG_MIN_TTL = 1'b0;

    // Per-line parse state
    typedef struct packed {
        logic        in_quotes;
        logic [2:0]  token_index;
        logic [2:0]  token_length;
        logic [2:0]  keyword_match;
        logic [1:0]  command_kind;
        logic [31:0] ttl_acc;
        logic [1:0]  ttl_phase;
        logic        ttl_negative;
        logic [7:0]  key_count;
        logic [10:0] value_count;
        logic        line_cut;
    } t_line_state;

    localparam t_line_state LINE_CLEAR = '{
        in_quotes:     1'b0,
        token_index:   3'd0,
        token_length:  3'd0,
        keyword_match: 3'b111,
        command_kind:  OP_NONE,
        ttl_acc:       32'd0,
        ttl_phase:     TTL_LEAD,
        ttl_negative:  1'b0,
        key_count:     8'd0,
        value_count:   11'd0,
        line_cut:      1'b0
    };

    // One result item plus its valid flag
    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [1:0]  operation;
        logic [30:0] ttl_seconds;
        logic [7:0]  key_length;
        logic [10:0] value_length;
    } t_result;

    // Keyword characters: word 0 get, 1 set, 2 del
    function automatic logic [7:0] word_char(input logic [1:0] w, input logic [1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case ({w, pos})
            4'b00_00: c = "g";
            4'b00_01: c = "e";
            4'b00_10: c = "t";
            4'b01_00: c = "s";
            4'b01_01: c = "e";
            4'b01_10: c = "t";
            4'b10_00: c = "d";
            4'b10_01: c = "e";
            4'b10_10: c = "l";
            default:  c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: src/kvclp_step.sv
// Per-byte parse step: next line state and the result caused by one item.
module kvclp_step (
    input  kvclp_pkg::t_line_state i_state,
    input  logic [7:0]             i_line_byte,
    input  logic                   i_end_of_line,
    input  logic [30:0]            i_min_ttl,
    output kvclp_pkg::t_line_state o_state,
    output kvclp_pkg::t_result     o_result
);
    import kvclp_pkg::*;

    // Close the token in progress; the first token picks the command
    function automatic t_line_state finish_token(input t_line_state st);
        t_line_state s;
        s = st;
        if (s.token_length != 3'd0) begin
            if (s.token_index == 3'd0) begin
                s.command_kind = OP_NONE;
                if (s.token_length == 3'd3) begin
                    priority if (s.keyword_match[0]) begin
                        s.command_kind = OP_GET;
                    end else if (s.keyword_match[1]) begin
                        s.command_kind = OP_SET;
                    end else if (s.keyword_match[2]) begin
                        s.command_kind = OP_DEL;
                    end else begin
                        s.command_kind = OP_NONE;
                    end
                end
            end
            if (s.token_index < 3'd4) begin
                s.token_index = s.token_index + 3'd1;
            end
            s.token_length = 3'd0;
        end
        return s;
    endfunction

    // atoi-style TTL accumulation, magnitude saturates at 2^31
    function automatic t_line_state ttl_feed(input t_line_state st, input logic [7:0] b);
        t_line_state s;
        logic        digit;
        logic        take;
        logic [35:0] v;
        s     = st;
        digit = (b >= "0") && (b <= "9");
        take  = 1'b0;
        unique case (s.ttl_phase)
            TTL_LEAD: begin
                if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
                    take = 1'b0;
                end else if (b == "+" || b == "-") begin
                    s.ttl_negative = (b == "-");
                    s.ttl_phase    = TTL_DIGITS;
                end else if (!digit) begin
                    s.ttl_phase = TTL_STOP;
                end else begin
                    s.ttl_phase = TTL_DIGITS;
                    take        = 1'b1;
                end
            end
            TTL_DIGITS: begin
                if (digit) begin
                    take = 1'b1;
                end else begin
                    s.ttl_phase = TTL_STOP;
                end
            end
            default: take = 1'b0;
        endcase
        if (take) begin
            v = {1'b0, s.ttl_acc, 3'b000} + {3'b000, s.ttl_acc, 1'b0} + {32'd0, b[3:0]};
            s.ttl_acc = (v > 36'h0_8000_0000) ? 32'h8000_0000 : v[31:0];
        end
        return s;
    endfunction

    t_line_state s;
    t_result     res;
    logic [7:0]  b;
    logic        is_white;
    logic        is_quote;
    logic        do_append;
    logic [2:0]  key_at;
    logic [1:0]  op;
    logic [30:0] ttl;

    always_comb begin
        s         = i_state;
        res       = '0;
        b         = i_line_byte;
        is_white  = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
        is_quote  = (b == 8'h27) || (b == 8'h22);
        do_append = 1'b0;
        key_at    = 3'd1;
        op        = OP_NONE;
        ttl       = 31'd0;

        if (i_end_of_line) begin
            // Summary; an open quote drops its token
            if (!s.in_quotes) begin
                s = finish_token(s);
            end
            if (s.token_index >= 3'd2 && s.command_kind != OP_NONE &&
                (s.command_kind != OP_SET || s.token_index >= 3'd4)) begin
                op = s.command_kind;
            end
            if (s.ttl_negative) begin
                ttl = i_min_ttl;
            end else begin
                ttl = s.ttl_acc[31] ? {31{1'b1}} : s.ttl_acc[30:0];
                if (ttl < i_min_ttl) begin
                    ttl = i_min_ttl;
                end
            end
            res.valid     = 1'b1;
            res.kind      = KIND_SUMMARY;
            res.operation = op;
            if (op != OP_NONE) begin
                res.key_length = s.key_count;
            end
            if (op == OP_SET) begin
                res.ttl_seconds  = ttl;
                res.value_length = s.value_count;
            end
            s = LINE_CLEAR;
        end else if (s.line_cut) begin
            // rest of the line after a zero byte is ignored
            do_append = 1'b0;
        end else if (b == 8'h00) begin
            s.line_cut = 1'b1;
        end else if (s.in_quotes) begin
            if (is_quote) begin
                s           = finish_token(s);
                s.in_quotes = 1'b0;
            end else begin
                do_append = 1'b1;
            end
        end else if (is_white) begin
            s = finish_token(s);
        end else if (is_quote) begin
            s           = finish_token(s);
            s.in_quotes = 1'b1;
        end else begin
            do_append = 1'b1;
        end

        // Add the byte to the token in progress
        if (do_append) begin
            if (s.token_index == 3'd0 && s.token_length < 3'd3) begin
                for (int w = 0; w < 3; w++) begin
                    if (word_char(w[1:0], s.token_length[1:0]) != b) begin
                        s.keyword_match[w] = 1'b0;
                    end
                end
            end
            key_at = (s.command_kind == OP_SET) ? 3'd2 : 3'd1;
            if (s.token_index >= 3'd1 && s.command_kind != OP_NONE) begin
                if (s.command_kind == OP_SET && s.token_index == 3'd1) begin
                    s = ttl_feed(s, b);
                end
                if (s.token_index == key_at) begin
                    if (s.key_count < KEY_MAX_LEN) begin
                        s.key_count   = s.key_count + 8'd1;
                        res.valid     = 1'b1;
                        res.kind      = KIND_KEY;
                        res.data_byte = b;
                    end
                end else if (s.command_kind == OP_SET && s.token_index == 3'd3) begin
                    if (s.value_count < VALUE_MAX_LEN) begin
                        s.value_count = s.value_count + 11'd1;
                        res.valid     = 1'b1;
                        res.kind      = KIND_VALUE;
                        res.data_byte = b;
                    end
                end
            end
            if (s.token_length < 3'd4) begin
                s.token_length = s.token_length + 3'd1;
            end
        end
    end

    assign o_state  = s;
    assign o_result = res;

endmodule

// File: src/kv_command_line_parser.sv
// Command line parser for a key-value store: top level, handshake and register port.
// A result appears in the output register in the cycle after the input transfer.
// Throughput: one byte per cycle while o_in_ready is high; the per-byte state update is a single register stage.
// o_in_ready drops only while the output register holds a result that is not taken.
// Reset (synchronous, active low) clears the line state and output valid, min_ttl to 10.
// There is no clearing pass; the block accepts items in the first cycle after reset.
module kv_command_line_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_line_byte,
    input  logic        i_end_of_line,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [1:0]  o_operation,
    output logic [30:0] o_ttl_seconds,
    output logic [7:0]  o_key_length,
    output logic [10:0] o_value_length
);
    import kvclp_pkg::*;
    `include "kv_command_line_parser_assert.svh"

    logic [30:0] r_min_ttl;
    t_line_state r_state;
    t_line_state n_state;
    t_result     step_res;
    logic        r_out_valid;
    logic        n_out_valid;
    t_result     r_out;
    logic        in_xfer;
    logic        cfg_wr;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MIN_TTL);
    assign prdata = (paddr[2] == REG_MIN_TTL) ? {1'b0, r_min_ttl} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ttl <= MIN_TTL_RESET;
        end else if (cfg_wr) begin
            r_min_ttl <= pwdata[30:0];
        end
    end

    // Parse step
    kvclp_step u_step (
        .i_state       (r_state),
        .i_line_byte   (i_line_byte),
        .i_end_of_line (i_end_of_line),
        .i_min_ttl     (r_min_ttl),
        .o_state       (n_state),
        .o_result      (step_res)
    );

    // Input transfer whenever the output register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        if (in_xfer && step_res.valid) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= LINE_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_xfer) begin
                r_state <= n_state;
            end
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (in_xfer && step_res.valid) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_data_byte    = r_out.data_byte;
    assign o_operation    = r_out.operation;
    assign o_ttl_seconds  = r_out.ttl_seconds;
    assign o_key_length   = r_out.key_length;
    assign o_value_length = r_out.value_length;

    // Checks
    `KVCLP_ASSERT_IMP(a_no_overwrite, r_out_valid && !i_out_ready, !o_in_ready)
    `KVCLP_ASSERT_NXT(a_eol_summary, in_xfer && i_end_of_line,
                      o_out_valid && o_kind == KIND_SUMMARY)
    `KVCLP_ASSERT_NXT(a_eol_clears, in_xfer && i_end_of_line,
                      r_state.token_index == 3'd0 && !r_state.in_quotes)
    `KVCLP_ASSERT_IMP(a_none_zero, o_out_valid && o_kind == KIND_SUMMARY && o_operation == OP_NONE,
                      o_ttl_seconds == 31'd0 && o_key_length == 8'd0 && o_value_length == 11'd0)
    `KVCLP_ASSERT_IMP(a_byte_no_op, o_out_valid && o_kind != KIND_SUMMARY,
                      o_operation == OP_NONE)

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the key-value command line parser.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kvclp_pkg::*;

    localparam int          CLK_HALF      = 6;
    localparam int          RESET_CYCLES  = 9;
    localparam int          DRAIN_CYCLES  = 4;
    localparam int          CYCLE_LIMIT   = 300000;
    localparam int          PHASE_ITEMS   = 130;
    localparam int          NUM_PHASES    = 5;
    localparam logic [2:0]  ADDR_MIN_TTL  = 3'(REG_MIN_TTL) * 3'd4;
    localparam logic [2:0]  ADDR_UNMAPPED = 3'd4;
    localparam logic [31:0] TTL_SAT       = 32'h8000_0000;
    localparam logic [30:0] TTL_MAX       = 31'h7fff_ffff;
    localparam logic [23:0] KW_TEXT [3]   = '{"get", "set", "del"};
    localparam logic [1:0]  KW_OPS  [3]   = '{OP_GET, OP_SET, OP_DEL};

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [1:0]  op;
        logic [30:0] ttl;
        logic [7:0]  klen;
        logic [10:0] vlen;
    } parse_result_t;

    typedef struct {
        string         text;
        logic [7:0]    pad_ch;
        int            pad_n;
        bit            typed;
        parse_result_t summary;
    } cmd_row_t;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_line_byte    = '0;
    logic        i_end_of_line  = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [1:0]  o_operation;
    logic [30:0] o_ttl_seconds;
    logic [7:0]  o_key_length;
    logic [10:0] o_value_length;

    kv_command_line_parser dut (.*);

    // Parser mirror state
    logic        quoted;
    logic [2:0]  tok_idx;
    logic [2:0]  tok_len;
    logic [2:0]  kw_hits;
    logic [1:0]  cmd;
    logic [31:0] ttl_mag;
    logic [1:0]  ttl_state;
    logic        ttl_neg;
    logic [7:0]  key_cnt;
    logic [10:0] val_cnt;
    logic        cut;
    logic [30:0] min_ttl_cfg = MIN_TTL_RESET;

    parse_result_t pending_parse_outputs[$];
    cmd_row_t      cmd_rows[$];
    logic [7:0]    line_bytes[$];

    int errors = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int lines_sent = 0;
    int keys_seen = 0;
    int values_seen = 0;
    int summaries_seen = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
    end

    // Receiver back-pressure
    always @(posedge i_clk) i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    function automatic bit is_space(logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
    endfunction

    function automatic bit is_quote(logic [7:0] b);
        return b == 8'h27 || b == 8'h22;
    endfunction

    task automatic clear_line();
        quoted    = 1'b0;
        tok_idx   = '0;
        tok_len   = '0;
        kw_hits   = 3'b111;
        cmd       = OP_NONE;
        ttl_mag   = '0;
        ttl_state = TTL_LEAD;
        ttl_neg   = 1'b0;
        key_cnt   = '0;
        val_cnt   = '0;
        cut       = 1'b0;
    endtask

    // Queue appends
    task automatic queue_result(parse_result_t r);
        pending_parse_outputs.insert(pending_parse_outputs.size(), r);
    endtask

    task automatic line_add(logic [7:0] b);
        line_bytes.insert(line_bytes.size(), b);
    endtask

    task automatic close_token();
        if (tok_len == 0) return;
        if (tok_idx == 0) begin
            cmd = OP_NONE;
            // lowest matching keyword wins
            if (tok_len == 3)
                for (int w = 2; w >= 0; w--)
                    if (kw_hits[w]) cmd = KW_OPS[w];
        end
        if (tok_idx < 4) tok_idx++;
        tok_len = 0;
    endtask

    // atoi-style TTL accumulation, magnitude saturates
    task automatic feed_ttl(logic [7:0] b);
        bit          digit;
        logic [63:0] v;
        digit = b >= "0" && b <= "9";
        case (ttl_state)
            TTL_LEAD: begin
                if (is_space(b)) return;
                if (b == "+" || b == "-") begin
                    ttl_neg   = (b == "-");
                    ttl_state = TTL_DIGITS;
                    return;
                end
                if (!digit) begin
                    ttl_state = TTL_STOP;
                    return;
                end
                ttl_state = TTL_DIGITS;
            end
            TTL_DIGITS: begin
                if (!digit) begin
                    ttl_state = TTL_STOP;
                    return;
                end
            end
            default: return;
        endcase
        v = 64'(ttl_mag) * 64'd10 + 64'(b) - 64'd48;
        ttl_mag = (v > 64'(TTL_SAT)) ? TTL_SAT : v[31:0];
    endtask

    task automatic take_byte(logic [7:0] b);
        parse_result_t r;
        logic [2:0]    key_tok;
        r = '0;
        if (tok_idx == 0 && tok_len < 3)
            for (int w = 0; w < 3; w++)
                if (KW_TEXT[w][8 * (2 - int'(tok_len)) +: 8] != b) kw_hits[w] = 1'b0;
        key_tok = (cmd == OP_SET) ? 3'd2 : 3'd1;
        if (tok_idx >= 1 && cmd != OP_NONE) begin
            if (cmd == OP_SET && tok_idx == 1) feed_ttl(b);
            if (tok_idx == key_tok) begin
                if (key_cnt < KEY_MAX_LEN) begin
                    key_cnt++;
                    r.kind = KIND_KEY;
                    r.data = b;
                    queue_result(r);
                end
            end else if (cmd == OP_SET && tok_idx == 3) begin
                if (val_cnt < VALUE_MAX_LEN) begin
                    val_cnt++;
                    r.kind = KIND_VALUE;
                    r.data = b;
                    queue_result(r);
                end
            end
        end
        if (tok_len < 4) tok_len++;
    endtask

    // Predict the outputs caused by one accepted character or terminator
    task automatic parse_char(logic [7:0] b, logic eol);
        parse_result_t r;
        logic [30:0]   t;
        r = '0;
        if (eol) begin
            if (!quoted) close_token();
            r.kind = KIND_SUMMARY;
            r.op   = OP_NONE;
            if (tok_idx >= 2 && cmd != OP_NONE && (cmd != OP_SET || tok_idx >= 4))
                r.op = cmd;
            if (r.op != OP_NONE) r.klen = key_cnt;
            if (r.op == OP_SET) begin
                if (ttl_neg) begin
                    t = min_ttl_cfg;
                end else begin
                    t = (ttl_mag > 32'(TTL_MAX)) ? TTL_MAX : ttl_mag[30:0];
                    if (t < min_ttl_cfg) t = min_ttl_cfg;
                end
                r.ttl  = t;
                r.vlen = val_cnt;
            end
            queue_result(r);
            clear_line();
            return;
        end
        if (cut) return;
        if (b == 8'h00) begin
            cut = 1'b1;
            return;
        end
        if (quoted) begin
            if (is_quote(b)) begin
                close_token();
                quoted = 1'b0;
            end else begin
                take_byte(b);
            end
            return;
        end
        if (is_space(b)) begin
            close_token();
        end else if (is_quote(b)) begin
            close_token();
            quoted = 1'b1;
        end else begin
            take_byte(b);
        end
    endtask

    // Output monitor and scoreboard
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        parse_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_parse_outputs.size() == 0) begin
                $display("%0t ns: output transfer with nothing expected, expected none, actual kind %0h data %0h",
                         $time, o_kind, o_data_byte);
                errors++;
            end else begin
                want = pending_parse_outputs.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_kind));
                check_field("data_byte", 32'(want.data), 32'(o_data_byte));
                check_field("operation", 32'(want.op), 32'(o_operation));
                check_field("ttl_seconds", 32'(want.ttl), 32'(o_ttl_seconds));
                check_field("key_length", 32'(want.klen), 32'(o_key_length));
                check_field("value_length", 32'(want.vlen), 32'(o_value_length));
            end
            case (o_kind)
                KIND_KEY:   keys_seen++;
                KIND_VALUE: values_seen++;
                default:    summaries_seen++;
            endcase
        end
    end

    // Input channel driver, called from the main sequence in step with i_clk
    task automatic send_item(logic [7:0] b, logic eol);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_line_byte   <= b;
        i_end_of_line <= eol;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        parse_char(b, eol);
    endtask

    task automatic send_line(bit typed, parse_result_t summary);
        foreach (line_bytes[i]) send_item(line_bytes[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        lines_sent++;
        if (typed) begin
            void'(pending_parse_outputs.pop_back());
            queue_result(summary);
        end
    endtask

    task automatic wait_parser_idle();
        i_in_valid <= 1'b0;
        while (pending_parse_outputs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register port: setup phase, then access phase, then an idle phase
    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_MIN_TTL) min_ttl_cfg = data[30:0];
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(logic [2:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field("min_ttl readback", {1'b0, min_ttl_cfg}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_row(string text, logic [7:0] pad_ch, int pad_n, bit typed,
                           logic [1:0] op, logic [30:0] ttl, logic [7:0] klen,
                           logic [10:0] vlen);
        cmd_row_t row;
        row.text    = text;
        row.pad_ch  = pad_ch;
        row.pad_n   = pad_n;
        row.typed   = typed;
        row.summary = '{kind: KIND_SUMMARY, data: 8'h00, op: op, ttl: ttl, klen: klen, vlen: vlen};
        cmd_rows.insert(cmd_rows.size(), row);
    endtask

    // Random line pieces
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 255)); while (is_quote(c));
        return c;
    endfunction

    function automatic logic [7:0] quoted_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (is_quote(c));
        return c;
    endfunction

    function automatic logic [7:0] quote_char();
        return $urandom_range(0, 1) ? 8'h27 : 8'h22;
    endfunction

    task automatic put_sep();
        int r;
        repeat ($urandom_range(1, 3)) begin
            r = $urandom_range(0, 9);
            line_add(r < 5 ? 8'h20 : 8'h09 + 8'(r - 5));
        end
    endtask

    task automatic put_word(int n, bit q);
        if (q) line_add(quote_char());
        repeat (n) line_add(q ? quoted_char() : plain_char());
        if (q) line_add(quote_char());
    endtask

    task automatic put_text(string s, bit q);
        if (q) line_add(quote_char());
        for (int i = 0; i < s.len(); i++) line_add(s[i]);
        if (q) line_add(quote_char());
    endtask

    task automatic put_digits(int n);
        repeat (n) line_add(8'($urandom_range(48, 57)));
    endtask

    task automatic put_ttl();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: put_digits($urandom_range(1, 3));
            4: put_digits($urandom_range(6, 12));
            5: begin
                line_add("-");
                put_digits($urandom_range(0, 4));
            end
            6: begin
                line_add("+");
                put_digits($urandom_range(1, 10));
            end
            7: begin
                // whitespace ahead of the digits only survives inside quotes
                line_add(quote_char());
                put_sep();
                put_digits($urandom_range(1, 4));
                line_add(quote_char());
            end
            8: begin
                put_digits($urandom_range(1, 3));
                put_word($urandom_range(1, 3), 1'b0);
            end
            default: put_word($urandom_range(1, 4), 1'b0);
        endcase
    endtask

    task automatic put_keyword(output bit is_set);
        int w;
        is_set = 1'b0;
        if ($urandom_range(0, 99) < 85) begin
            w = $urandom_range(0, 3);
            is_set = (w == 1 || w == 2);
            put_text(w == 0 ? "get" : (w == 3 ? "del" : "set"), $urandom_range(0, 9) == 0);
        end else begin
            case ($urandom_range(0, 3))
                0: put_text("ge", 1'b0);
                1: put_text("sett", 1'b0);
                2: put_text("sel", 1'b0);
                default: put_word($urandom_range(1, 5), 1'b0);
            endcase
        end
    endtask

    task automatic build_random_line();
        int r;
        int ntok;
        int klen;
        bit is_set;
        line_bytes.delete();
        // raw noise lines
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(0, 20)) line_add(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 9) < 3) put_sep();
        put_keyword(is_set);
        ntok = is_set ? 3 : 1;
        r = $urandom_range(0, 99);
        if (r < 8) ntok--;
        else if (r < 16) ntok += $urandom_range(1, 2);
        for (int i = 1; i <= ntok; i++) begin
            put_sep();
            if (is_set && i == 1) begin
                put_ttl();
            end else if (i == (is_set ? 2 : 1)) begin
                klen = ($urandom_range(0, 99) < 2) ? $urandom_range(250, 260)
                                                   : $urandom_range(1, 10);
                put_word(klen, $urandom_range(0, 3) == 0);
            end else begin
                put_word($urandom_range(0, 16), $urandom_range(0, 2) == 0);
            end
            // a zero byte cuts the rest of the line
            if ($urandom_range(0, 99) < 3) begin
                line_add(8'h00);
                put_word($urandom_range(0, 4), 1'b0);
            end
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            put_sep();
            line_add(quote_char());
            repeat ($urandom_range(0, 6)) line_add(quoted_char());
        end else if (r < 25) begin
            put_sep();
        end
    endtask

    // Main sequence
    initial begin
        logic [30:0] ttl_setting;
        int          phase_start;
        bit          paused;

        clear_line();
        send_idle_pct = 25;
        recv_idle_pct = 47;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines; '~' stands for a zero byte
        add_row("get", 8'h00, 0, 1, OP_NONE, 0, 0, 0);
        add_row("get k1", 8'h00, 0, 1, OP_GET, 0, 2, 0);
        add_row("  del \tkey  ", 8'h00, 0, 1, OP_DEL, 0, 3, 0);
        add_row("set 100 k v", 8'h00, 0, 1, OP_SET, 100, 1, 1);
        add_row("set 5 k v", 8'h00, 0, 1, OP_SET, 10, 1, 1);
        add_row("set -7 k v", 8'h00, 0, 1, OP_SET, 10, 1, 1);
        add_row("set 99999999999 k v", 8'h00, 0, 1, OP_SET, TTL_MAX, 1, 1);
        add_row("set 2147483648 k v", 8'h00, 0, 1, OP_SET, TTL_MAX, 1, 1);
        add_row("set 2147483647 k v", 8'h00, 0, 1, OP_SET, TTL_MAX, 1, 1);
        add_row("set +42x k v", 8'h00, 0, 1, OP_SET, 42, 1, 1);
        add_row("set abc k v", 8'h00, 0, 1, OP_SET, 10, 1, 1);
        add_row("set 'a b' \"k k\" 'v\"", 8'h00, 0, 1, OP_SET, 10, 3, 1);
        add_row("get '' k", 8'h00, 0, 1, OP_GET, 0, 1, 0);
        add_row("get 'open k", 8'h00, 0, 1, OP_NONE, 0, 0, 0);
        add_row("get k~junk", 8'h00, 0, 1, OP_GET, 0, 1, 0);
        add_row("put k", 8'h00, 0, 1, OP_NONE, 0, 0, 0);
        add_row("gets k", 8'h00, 0, 1, OP_NONE, 0, 0, 0);
        add_row("", 8'h00, 0, 1, OP_NONE, 0, 0, 0);
        add_row("set 1 k", 8'h00, 0, 1, OP_NONE, 0, 0, 0);
        add_row("\377et k", 8'h00, 0, 1, OP_NONE, 0, 0, 0);
        add_row("get\015\n\013\014k", 8'h00, 0, 1, OP_GET, 0, 1, 0);
        add_row("del k extra more", 8'h00, 0, 1, OP_DEL, 0, 1, 0);
        add_row("get ", "a", 260, 1, OP_GET, 0, KEY_MAX_LEN, 0);
        add_row("set 0 k ", "v", 20, 1, OP_SET, 10, 1, 20);
        add_row("set 007 \"a\tb\" 'x y\200\377'", 8'h00, 0, 0, OP_NONE, 0, 0, 0);
        add_row("set  \t12ab key \"'", 8'h00, 0, 0, OP_NONE, 0, 0, 0);

        foreach (cmd_rows[i]) begin
            line_bytes.delete();
            for (int c = 0; c < cmd_rows[i].text.len(); c++)
                line_add(cmd_rows[i].text[c] == "~" ? 8'h00 : cmd_rows[i].text[c]);
            repeat (cmd_rows[i].pad_n) line_add(cmd_rows[i].pad_ch);
            send_line(cmd_rows[i].typed, cmd_rows[i].summary);
        end
        wait_parser_idle();

        // Unmapped register address must leave min_ttl alone
        apb_write(ADDR_UNMAPPED, 32'h0000_0003);
        apb_read_check(ADDR_MIN_TTL);

        // Random phases: one min_ttl setting and one idle mode each
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: ttl_setting = '0;
                1: ttl_setting = TTL_MAX;
                2: ttl_setting = 31'($urandom_range(0, 200));
                3: ttl_setting = 31'($urandom);
                default: ttl_setting = 31'd1;
            endcase
            apb_write(ADDR_MIN_TTL, {1'($urandom_range(0, 1)), ttl_setting});
            apb_read_check(ADDR_MIN_TTL);
            send_idle_pct = (ph == 0) ? 25 : (ph < 3 ? 47 : 0);
            recv_idle_pct = (ph == 0) ? 47 : (ph < 3 ? 25 : 0);
            phase_start = items_sent;
            paused = 1'b0;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                build_random_line();
                send_line(1'b0, '0);
                // one hold-off until the parser has drained
                if (ph == 2 && !paused && items_sent - phase_start > PHASE_ITEMS / 2) begin
                    wait_parser_idle();
                    paused = 1'b1;
                end
            end
            wait_parser_idle();
        end

        $display("covered %0d items in %0d lines across %0d min_ttl settings and three idle mixes",
                 items_sent, lines_sent, NUM_PHASES + 1);
        $display("outputs checked: %0d key bytes, %0d value bytes, %0d line summaries",
                 keys_seen, values_seen, summaries_seen);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule
